// ===== src/mre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mre_pkg
// Shared types and constants for the mouse report event generator.
// ----------------------------------------------------------------------------
package mre_pkg;

  typedef enum logic [2:0] {
    EV_WHEEL   = 3'd0,
    EV_LDOWN   = 3'd1,
    EV_LUP     = 3'd2,
    EV_LDOUBLE = 3'd3,
    EV_RDOWN   = 3'd4,
    EV_RUP     = 3'd5,
    EV_RDOUBLE = 3'd6,
    EV_MOVE    = 3'd7
  } event_kind_e;

  localparam logic [1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [1:0] CFG_SCREEN_H = 2'd1;
  localparam logic [1:0] CFG_DCLICK   = 2'd2;

  localparam logic [15:0] SCREEN_W_RST = 16'd1920;
  localparam logic [15:0] SCREEN_H_RST = 16'd1080;
  localparam logic [15:0] DCLICK_RST   = 16'd500;

  localparam int unsigned PRESS_BIT = 7;

  // event slots in output order
  localparam int unsigned NSLOTS    = 6;
  localparam int unsigned SL_WHEEL  = 0;
  localparam int unsigned SL_LDOWN  = 1;
  localparam int unsigned SL_LUP    = 2;
  localparam int unsigned SL_RDOWN  = 3;
  localparam int unsigned SL_RUP    = 4;
  localparam int unsigned SL_MOVE   = 5;

  typedef struct packed {
    logic [NSLOTS-1:0]  slots;
    logic               l_dbl;
    logic               r_dbl;
    logic [15:0]        pre_x;
    logic [15:0]        pre_y;
    logic [15:0]        post_x;
    logic [15:0]        post_y;
    logic signed [15:0] wheel;
  } evt_desc_t;

endpackage
`default_nettype wire

// ===== src/mre_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mre_front
// Accepts reports, updates cursor and button state, builds event descriptors.
// ----------------------------------------------------------------------------
module mre_front
  import mre_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire logic signed [15:0] move_dx_i,
  input  wire logic signed [15:0] move_dy_i,
  input  wire logic signed [15:0] wheel_dz_i,
  input  wire logic [7:0]         left_buttons_i,
  input  wire logic [7:0]         right_buttons_i,
  input  wire logic [31:0]        now_ms_i,
  input  wire logic               q_full_i,
  output logic                    push_o,
  output evt_desc_t               desc_o
);

  logic [15:0] width_q, width_d, height_q, height_d, dclick_q, dclick_d;
  logic [15:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [7:0]  prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  logic [31:0] rel_l_q, rel_l_d, rel_r_q, rel_r_d;

  logic        accept;
  logic        l_chg, r_chg, l_down, l_up, r_down, r_up, moved;
  logic [31:0] l_gap, r_gap;
  logic [15:0] new_x, new_y;

  function automatic logic [15:0] clamp_axis(input logic [15:0] pos,
                                             input logic signed [15:0] d,
                                             input logic [15:0] lim);
    logic signed [17:0] sum;
    sum = $signed({2'b00, pos}) + 18'(d);
    if (sum < 0) begin
      return 16'd0;
    end else if (sum[16:0] > {1'b0, lim}) begin
      return lim;
    end else begin
      return sum[15:0];
    end
  endfunction

  assign accept = in_valid_i && !q_full_i;

  always_comb begin
    l_chg  = left_buttons_i != prev_l_q;
    r_chg  = right_buttons_i != prev_r_q;
    l_down = l_chg && left_buttons_i[PRESS_BIT];
    l_up   = l_chg && prev_l_q[PRESS_BIT];
    r_down = r_chg && right_buttons_i[PRESS_BIT];
    r_up   = r_chg && prev_r_q[PRESS_BIT];
    l_gap  = now_ms_i - rel_l_q;
    r_gap  = now_ms_i - rel_r_q;
    moved  = (move_dx_i != 16'sd0) || (move_dy_i != 16'sd0);
    new_x  = clamp_axis(cur_x_q, move_dx_i, width_q);
    new_y  = clamp_axis(cur_y_q, move_dy_i, height_q);

    desc_o.slots           = '0;
    desc_o.slots[SL_WHEEL] = wheel_dz_i != 16'sd0;
    desc_o.slots[SL_LDOWN] = l_down;
    desc_o.slots[SL_LUP]   = l_up;
    desc_o.slots[SL_RDOWN] = r_down;
    desc_o.slots[SL_RUP]   = r_up;
    desc_o.slots[SL_MOVE]  = moved;
    desc_o.l_dbl  = l_gap < {16'd0, dclick_q};
    desc_o.r_dbl  = r_gap < {16'd0, dclick_q};
    desc_o.pre_x  = cur_x_q;
    desc_o.pre_y  = cur_y_q;
    desc_o.post_x = new_x;
    desc_o.post_y = new_y;
    desc_o.wheel  = wheel_dz_i;

    push_o = accept && (desc_o.slots != '0);
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    dclick_d = dclick_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    prev_l_d = prev_l_q;
    prev_r_d = prev_r_q;
    rel_l_d  = rel_l_q;
    rel_r_d  = rel_r_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCREEN_W: begin
          width_d = cfg_data_i;
          cur_x_d = cfg_data_i >> 1;
          cur_y_d = height_q >> 1;
        end
        CFG_SCREEN_H: begin
          height_d = cfg_data_i;
          cur_x_d  = width_q >> 1;
          cur_y_d  = cfg_data_i >> 1;
        end
        CFG_DCLICK: dclick_d = cfg_data_i;
        default: ;
      endcase
    end else if (accept) begin
      prev_l_d = left_buttons_i;
      prev_r_d = right_buttons_i;
      if (l_up) begin
        rel_l_d = now_ms_i;
      end
      if (r_up) begin
        rel_r_d = now_ms_i;
      end
      if (moved) begin
        cur_x_d = new_x;
        cur_y_d = new_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SCREEN_W_RST;
      height_q <= SCREEN_H_RST;
      dclick_q <= DCLICK_RST;
      cur_x_q  <= SCREEN_W_RST >> 1;
      cur_y_q  <= SCREEN_H_RST >> 1;
      prev_l_q <= '0;
      prev_r_q <= '0;
      rel_l_q  <= '0;
      rel_r_q  <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      dclick_q <= dclick_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      prev_l_q <= prev_l_d;
      prev_r_q <= prev_r_d;
      rel_l_q  <= rel_l_d;
      rel_r_q  <= rel_r_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/mre_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mre_fifo
// Small register queue of event descriptors between front and back.
// ----------------------------------------------------------------------------
module mre_fifo
  import mre_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire evt_desc_t push_data_i,
  input  wire logic      pop_i,
  output evt_desc_t      pop_data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  evt_desc_t     mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = cnt_q == CntW'(DEPTH);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/mre_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mre_back
// Drains one descriptor as a sequence of events, one per transfer.
// ----------------------------------------------------------------------------
module mre_back
  import mre_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire evt_desc_t          q_data_i,
  input  wire logic               q_empty_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              event_kind_o,
  output logic [15:0]             pos_x_o,
  output logic [15:0]             pos_y_o,
  output logic signed [15:0]      wheel_delta_o,
  output logic                    last_event_o
);

  evt_desc_t         desc_q, desc_d;
  logic [NSLOTS-1:0] mask_q, mask_d, sel, rest;
  logic              advance;
  event_kind_e       kind;

  assign sel         = mask_q & (~mask_q + 1'b1);
  assign rest        = mask_q & ~sel;
  assign out_valid_o = mask_q != '0;
  assign advance     = out_valid_o && !out_stall_i;

  always_comb begin
    kind          = EV_MOVE;
    pos_x_o       = desc_q.pre_x;
    pos_y_o       = desc_q.pre_y;
    wheel_delta_o = 16'sd0;
    if (sel[SL_WHEEL]) begin
      kind          = EV_WHEEL;
      wheel_delta_o = desc_q.wheel;
    end else if (sel[SL_LDOWN]) begin
      kind = EV_LDOWN;
    end else if (sel[SL_LUP]) begin
      kind = desc_q.l_dbl ? EV_LDOUBLE : EV_LUP;
    end else if (sel[SL_RDOWN]) begin
      kind = EV_RDOWN;
    end else if (sel[SL_RUP]) begin
      kind = desc_q.r_dbl ? EV_RDOUBLE : EV_RUP;
    end else begin
      pos_x_o = desc_q.post_x;
      pos_y_o = desc_q.post_y;
    end
    event_kind_o = kind;
    last_event_o = rest == '0;
  end

  always_comb begin
    desc_d  = desc_q;
    mask_d  = mask_q;
    q_pop_o = 1'b0;
    if (!out_valid_o || (advance && rest == '0)) begin
      mask_d = '0;
      if (!q_empty_i) begin
        q_pop_o = 1'b1;
        desc_d  = q_data_i;
        mask_d  = q_data_i.slots;
      end
    end else if (advance) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
  end

endmodule
`default_nettype wire

// ===== src/mouse_report_event_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mouse_report_event_generator
// Turns relative mouse reports into wheel, button and move events.
//
// Input channel: one report per transfer (in_valid_i high, in_stall_o low).
// Output channel: one event per transfer (out_valid_o high, out_stall_i
// low); last_event_o marks the final event of a report. A report with no
// activity produces no event.
// The front stage updates cursor and button state at the input transfer and
// queues a descriptor; the back stage emits its events one per cycle while
// out_stall_i is low. With the block idle, a report's descriptor is written
// into the queue at its transfer and then loaded into the back stage's
// registers, from which its first event is offered. A report produces one
// to six events; reports are accepted every cycle while the queue has room,
// QUEUE_DEPTH descriptors deep.
// When the receiver stalls, the current event holds and the queue fills;
// once full, in_stall_o rises.
// Reset: screen 1920 x 1080, cursor centered, window 500 ms, buttons
// released, release times zero, queue empty. The user must make configuration
// writes only while no report is in flight; the block has no check for it.
// ----------------------------------------------------------------------------
module mouse_report_event_generator
  import mre_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] move_dx_i,
  input  wire logic signed [15:0] move_dy_i,
  input  wire logic signed [15:0] wheel_dz_i,
  input  wire logic [7:0]         left_buttons_i,
  input  wire logic [7:0]         right_buttons_i,
  input  wire logic [31:0]        now_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              event_kind_o,
  output logic [15:0]             pos_x_o,
  output logic [15:0]             pos_y_o,
  output logic signed [15:0]      wheel_delta_o,
  output logic                    last_event_o
);

  evt_desc_t push_data, pop_data;
  logic      push, pop, q_full, q_empty;

  assign in_stall_o = q_full;

  mre_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .move_dx_i       (move_dx_i),
    .move_dy_i       (move_dy_i),
    .wheel_dz_i      (wheel_dz_i),
    .left_buttons_i  (left_buttons_i),
    .right_buttons_i (right_buttons_i),
    .now_ms_i        (now_ms_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .desc_o          (push_data)
  );

  mre_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  mre_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_data_i      (pop_data),
    .q_empty_i     (q_empty),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .wheel_delta_o (wheel_delta_o),
    .last_event_o  (last_event_o)
  );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mouse_report_event_generator.
// Reports are queued by a stimulus thread and sent by a clocked driver with
// random gaps. A clocked monitor takes events with random stalls and checks
// each one against a cycle-free model of cursor, buttons and double-click
// timing. Screen size and double-click window are changed between phases,
// including both extremes and a window of zero.
// ----------------------------------------------------------------------------
module testbench;
  import mre_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         IDLE_LIMIT = 1000;
  localparam int         LONG_HOLD  = 80;
  localparam int         SETTLE     = 8;

  typedef struct {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dz;
    logic [7:0]         lb;
    logic [7:0]         rb;
    logic [31:0]        now;
  } report_t;

  typedef struct {
    event_kind_e        kind;
    logic [15:0]        x;
    logic [15:0]        y;
    logic signed [15:0] wheel;
    logic               last;
  } mouse_event_t;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    cfg_we_i        = 1'b0;
  logic [1:0]              cfg_idx_i       = CFG_SCREEN_W;
  logic [15:0]             cfg_data_i      = '0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic signed [15:0]      move_dx_i       = '0;
  logic signed [15:0]      move_dy_i       = '0;
  logic signed [15:0]      wheel_dz_i      = '0;
  logic [7:0]              left_buttons_i  = '0;
  logic [7:0]              right_buttons_i = '0;
  logic [31:0]             now_ms_i        = '0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic [2:0]              event_kind_o;
  logic [15:0]             pos_x_o;
  logic [15:0]             pos_y_o;
  logic signed [15:0]      wheel_delta_o;
  logic                    last_event_o;

  mouse_report_event_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .move_dx_i       (move_dx_i),
    .move_dy_i       (move_dy_i),
    .wheel_dz_i      (wheel_dz_i),
    .left_buttons_i  (left_buttons_i),
    .right_buttons_i (right_buttons_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .wheel_delta_o   (wheel_delta_o),
    .last_event_o    (last_event_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // tracker model state
  logic [15:0] scr_width  = SCREEN_W_RST;
  logic [15:0] scr_height = SCREEN_H_RST;
  logic [15:0] dclick_win = DCLICK_RST;
  logic [15:0] cur_x      = SCREEN_W_RST >> 1;
  logic [15:0] cur_y      = SCREEN_H_RST >> 1;
  logic [7:0]  prev_btn   [2];
  logic [31:0] release_ms [2];

  // stimulus-side view of the button history
  logic [7:0]  gen_prev_btn [2];
  logic [31:0] gen_release  [2];
  logic [31:0] gen_clock = '0;

  report_t      pending_reports [$];
  mouse_event_t expected_events [$];
  report_t      cur_report;

  bit report_taken = 1'b0;
  bit rx_hold_req  = 1'b0;
  int tx_wait   = 0;
  int rx_wait   = 0;
  int hold_left = 0;
  int tx_max    = 7;
  int rx_max    = 7;
  int idle_cycles = 0;
  int n_errors  = 0;
  int n_reports = 0;
  int n_events  = 0;
  int n_doubles = 0;
  int n_writes  = 0;

  initial begin
    prev_btn[0]     = '0;
    prev_btn[1]     = '0;
    release_ms[0]   = '0;
    release_ms[1]   = '0;
    gen_prev_btn[0] = '0;
    gen_prev_btn[1] = '0;
    gen_release[0]  = '0;
    gen_release[1]  = '0;
  end

  function automatic mouse_event_t mk_event(event_kind_e k, logic [15:0] x, logic [15:0] y,
                                            logic signed [15:0] w);
    mouse_event_t e;
    e.kind  = k;
    e.x     = x;
    e.y     = y;
    e.wheel = w;
    e.last  = 1'b0;
    return e;
  endfunction

  function automatic logic [15:0] clamp_axis(logic [15:0] pos, logic signed [15:0] d,
                                             logic [15:0] lim);
    int s;
    int l;
    s = pos;
    s = s + d;
    l = lim;
    if (s < 0) return 16'd0;
    if (s > l) return lim;
    return s[15:0];
  endfunction

  task automatic predict_report(input report_t r);
    mouse_event_t evs [6];
    event_kind_e  k;
    logic [7:0]   btn;
    logic [31:0]  gap;
    int           n;
    int           b;
    int           i;
    n = 0;
    if (r.dz != 0) begin
      evs[n] = mk_event(EV_WHEEL, cur_x, cur_y, r.dz);
      n++;
    end
    for (b = 0; b < 2; b++) begin
      btn = (b == 0) ? r.lb : r.rb;
      if (btn != prev_btn[b]) begin
        if (btn[PRESS_BIT]) begin
          if (b == 0) k = EV_LDOWN;
          else k = EV_RDOWN;
          evs[n] = mk_event(k, cur_x, cur_y, 16'sd0);
          n++;
        end
        if (prev_btn[b][PRESS_BIT]) begin
          gap = r.now - release_ms[b];
          if (gap < {16'd0, dclick_win}) begin
            if (b == 0) k = EV_LDOUBLE;
            else k = EV_RDOUBLE;
          end else begin
            if (b == 0) k = EV_LUP;
            else k = EV_RUP;
          end
          evs[n] = mk_event(k, cur_x, cur_y, 16'sd0);
          n++;
          release_ms[b] = r.now;
        end
      end
      prev_btn[b] = btn;
    end
    if (r.dx != 0 || r.dy != 0) begin
      cur_x  = clamp_axis(cur_x, r.dx, scr_width);
      cur_y  = clamp_axis(cur_y, r.dy, scr_height);
      evs[n] = mk_event(EV_MOVE, cur_x, cur_y, 16'sd0);
      n++;
    end
    for (i = 0; i < n; i++) begin
      evs[i].last = (i == n - 1);
      expected_events.push_back(evs[i]);
    end
  endtask

  // report channel
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_report(cur_report);
      n_reports++;
      report_taken = 1'b1;
      tx_wait = $urandom_range(0, tx_max);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || report_taken)) begin
      report_taken = 1'b0;
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid_i = 1'b0;
      end else if (pending_reports.size() > 0) begin
        cur_report      = pending_reports.pop_front();
        move_dx_i       = cur_report.dx;
        move_dy_i       = cur_report.dy;
        wheel_dz_i      = cur_report.dz;
        left_buttons_i  = cur_report.lb;
        right_buttons_i = cur_report.rb;
        now_ms_i        = cur_report.now;
        in_valid_i      = 1'b1;
      end else begin
        in_valid_i = 1'b0;
      end
    end
  end

  // event channel
  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    mouse_event_t exp_ev;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_events++;
      rx_wait = $urandom_range(0, rx_max);
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, got kind %0d at (%0d,%0d)",
                 $time, event_kind_o, pos_x_o, pos_y_o);
        n_errors++;
      end else begin
        exp_ev = expected_events.pop_front();
        check_field("event_kind", exp_ev.kind, event_kind_o);
        check_field("pos_x", exp_ev.x, pos_x_o);
        check_field("pos_y", exp_ev.y, pos_y_o);
        check_field("wheel_delta", exp_ev.wheel, wheel_delta_o);
        check_field("last_event", exp_ev.last, last_event_o);
        if (exp_ev.kind == EV_LDOUBLE || exp_ev.kind == EV_RDOUBLE) n_doubles++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold_req) begin
      hold_left   = LONG_HOLD;
      rx_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    case (idx)
      CFG_SCREEN_W: begin
        scr_width = val;
        cur_x     = scr_width >> 1;
        cur_y     = scr_height >> 1;
      end
      CFG_SCREEN_H: begin
        scr_height = val;
        cur_x      = scr_width >> 1;
        cur_y      = scr_height >> 1;
      end
      CFG_DCLICK: begin
        dclick_win = val;
      end
      default: begin
      end
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reports.size() > 0 || in_valid_i || expected_events.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic queue_report(input logic signed [15:0] dx, input logic signed [15:0] dy,
                              input logic signed [15:0] dz, input logic [7:0] lb,
                              input logic [7:0] rb, input logic [31:0] now);
    report_t r;
    r.dx  = dx;
    r.dy  = dy;
    r.dz  = dz;
    r.lb  = lb;
    r.rb  = rb;
    r.now = now;
    pending_reports.push_back(r);
    if (lb != gen_prev_btn[0] && gen_prev_btn[0][PRESS_BIT]) gen_release[0] = now;
    if (rb != gen_prev_btn[1] && gen_prev_btn[1][PRESS_BIT]) gen_release[1] = now;
    gen_prev_btn[0] = lb;
    gen_prev_btn[1] = rb;
    gen_clock       = now;
  endtask

  function automatic logic signed [15:0] rand_motion();
    int v;
    case ($urandom_range(0, 3))
      0: return 16'sd0;
      3: return 16'($urandom());
      default: begin
        v = $urandom_range(0, 100);
        v = v - 50;
        return v[15:0];
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_buttons(input logic [7:0] prev);
    case ($urandom_range(0, 5))
      0, 1:    return prev;
      2, 3:    return prev ^ 8'h80;
      4:       return {prev[7], 7'($urandom())};
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic queue_random(input int count);
    logic [7:0]  nb [2];
    logic [31:0] now;
    logic signed [15:0] dz;
    int i;
    int b;
    for (i = 0; i < count; i++) begin
      nb[0] = rand_buttons(gen_prev_btn[0]);
      nb[1] = rand_buttons(gen_prev_btn[1]);
      case ($urandom_range(0, 7))
        0:       now = $urandom();
        1:       now = gen_clock;
        default: now = gen_clock + $urandom_range(0, 2 * dclick_win + 2);
      endcase
      // aim some releases right at the window edge
      for (b = 0; b < 2; b++)
        if (nb[b] != gen_prev_btn[b] && gen_prev_btn[b][PRESS_BIT] &&
            $urandom_range(0, 2) == 0)
          now = gen_release[b] + dclick_win - $urandom_range(0, 1);
      dz = ($urandom_range(0, 1) == 0) ? 16'sd0 : rand_motion();
      queue_report(rand_motion(), rand_motion(), dz, nb[0], nb[1], now);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset screen, window of 500
    tx_max = 7;
    rx_max = 7;
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h00, 8'h00, 32'd0);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h80, 8'h00, 32'd10);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h00, 8'h00, 32'd100);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h80, 8'h00, 32'd200);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h00, 8'h00, 32'd600);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h80, 8'h00, 32'd700);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h00, 8'h00, 32'd1099);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h01, 8'h00, 32'd1200);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h02, 8'h00, 32'd1300);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h80, 8'h00, 32'd1400);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h81, 8'h00, 32'd5000);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h81, 8'h80, 32'd5100);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h81, 8'h00, 32'd9000);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h81, 8'h80, 32'd9005);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h81, 8'hFF, 32'd9015);
    // all six event slots in one report, cursor pinned at the far corner
    queue_report(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 8'hC0, 8'h80, 32'd9020);
    queue_report(16'sh7FFF, 16'sd0, 16'sd0, 8'hC0, 8'h80, 32'd9030);
    queue_report(-16'sh8000, -16'sh8000, -16'sh8000, 8'hC0, 8'h80, 32'd9040);
    queue_report(16'sd0, 16'sd1, 16'sd0, 8'hC0, 8'h80, 32'd9050);
    queue_report(16'sd1, 16'sd0, 16'sd0, 8'hC0, 8'h80, 32'd9060);
    // release interval across the tick wrap
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h00, 8'h80, 32'hFFFF_FFF0);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h80, 8'h80, 32'hFFFF_FFF8);
    queue_report(16'sd0, 16'sd0, 16'sd0, 8'h00, 8'h80, 32'h0000_0010);
    wait_idle();

    // largest screen and window; receiver backs up the block
    write_reg(CFG_SCREEN_W, 16'hFFFF);
    write_reg(CFG_SCREEN_H, 16'hFFFF);
    write_reg(CFG_DCLICK, 16'hFFFF);
    tx_max = 0;
    rx_hold_req = 1'b1;
    queue_random(70);
    wait_idle();

    // zero screen, window never fires
    write_reg(CFG_SCREEN_W, 16'h0000);
    write_reg(CFG_SCREEN_H, 16'h0000);
    write_reg(CFG_DCLICK, 16'h0000);
    tx_max = 7;
    rx_max = 0;
    queue_random(50);
    wait_idle();

    // back to back, no gaps on either side
    write_reg(CFG_SCREEN_W, 16'd1);
    write_reg(CFG_SCREEN_H, 16'($urandom_range(1, 4000)));
    write_reg(CFG_DCLICK, 16'($urandom_range(1, 1000)));
    tx_max = 0;
    rx_max = 0;
    queue_random(70);
    wait_idle();

    // unused register index must change nothing
    write_reg(CFG_UNUSED, 16'hFFFF);
    write_reg(CFG_SCREEN_W, SCREEN_W_RST);
    write_reg(CFG_DCLICK, DCLICK_RST);
    tx_max = 3;
    rx_max = 7;
    queue_random(50);
    wait_idle();
    queue_random(40);
    wait_idle();

    write_reg(CFG_SCREEN_W, 16'($urandom()));
    write_reg(CFG_SCREEN_H, 16'($urandom()));
    write_reg(CFG_DCLICK, 16'($urandom_range(1, 65535)));
    tx_max = 7;
    rx_max = 7;
    queue_random(70);
    wait_idle();

    $display("Covered %0d reports and %0d events (%0d double-clicks) over %0d register writes,",
             n_reports, n_events, n_doubles, n_writes);
    $display("with screen and window extremes, stalls and input backpressure.");
    if (n_errors == 0 && expected_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d events still expected", n_errors, expected_events.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
